>>> rtl/ldpm_pkg.sv
`default_nettype none

package ldpm_pkg;

	// Coordinate width of the pixel ports, signed Q12.4 at the default width.
	localparam int COORD_WIDTH = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_12 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TANG_12   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_34 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_56 = 3'd7;

	// Focal length 1.0 in unsigned Q16.16.
	localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

	// Pipelined divider: one quotient bit per stage, remainder as wide as the divisor.
	localparam int QUO_W      = 32;
	localparam int DIV_STAGES = QUO_W;
	localparam int DIV_W      = 40;

	typedef struct packed {
		logic signed [63:0] val;
		logic               clipped;
	} clip_t;

	// Clip a signed value to a signed range of the given bit count.
	function automatic clip_t clip64(input logic signed [63:0] v, input int unsigned bits);
		clip_t              r;
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		r.clipped = 1'b1;
		if (v > hi) begin
			r.val = hi;
		end else if (v < lo) begin
			r.val = lo;
		end else begin
			r.val     = v;
			r.clipped = 1'b0;
		end
		return r;
	endfunction

	// Apply the sign to a quotient magnitude and clip it to a signed quotient word.
	function automatic clip_t quo_sat(input logic neg, input logic ovf,
			input logic [QUO_W-1:0] q);
		clip_t r;
		r.clipped = 1'b0;
		if (neg) begin
			if (ovf || (q > (QUO_W'(1) << (QUO_W - 1)))) begin
				r.val     = -(64'sd1 <<< (QUO_W - 1));
				r.clipped = 1'b1;
			end else begin
				r.val = -signed'(64'(q));
			end
		end else begin
			if (ovf || q[QUO_W-1]) begin
				r.val     = (64'sd1 <<< (QUO_W - 1)) - 64'sd1;
				r.clipped = 1'b1;
			end else begin
				r.val = signed'(64'(q));
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ldpm_div.sv
`default_nettype none

module ldpm_div (
	input  wire                            clk,
	input  wire                            en,
	input  wire  [ldpm_pkg::DIV_W-1:0]     num_hi,
	input  wire  [ldpm_pkg::QUO_W-1:0]     num_lo,
	input  wire  [ldpm_pkg::DIV_W-1:0]     den,
	output logic [ldpm_pkg::QUO_W-1:0]     quo
);
	import ldpm_pkg::*;

	logic [DIV_W-1:0] rem_s [DIV_STAGES];
	logic [QUO_W-1:0] lo_s  [DIV_STAGES];
	logic [DIV_W-1:0] den_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];

	// Restoring division, one quotient bit per register stage.
	// The upper part of the dividend must be below the divisor.
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [DIV_W-1:0] rem_in;
		logic [QUO_W-1:0] lo_in;
		logic [DIV_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [DIV_W:0]   trial;
		logic [DIV_W:0]   diff;

		if (i == 0) begin : g_first
			assign rem_in = num_hi;
			assign lo_in  = num_lo;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign lo_in  = lo_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, lo_in[QUO_W-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
				lo_s[i]  <= {lo_in[QUO_W-2:0], 1'b0};
				den_s[i] <= den_in;
				quo_s[i] <= {quo_in[QUO_W-2:0], ~diff[DIV_W]};
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/lens_distortion_point_map_core.sv
// Pipeline: two 32-stage radix-2 dividers (normalization and rational factor)
// and 17 further stages.
// Throughput: one point per clock; a stall on the output freezes the whole pipeline.
// Reset (arst_n low, asynchronous): pipeline empty, focal lengths 1.0, all other
// configuration registers zero.
`default_nettype none

module lens_distortion_point_map_core (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      wr_en,
	input  wire         [ldpm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire         [ldpm_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wire                                      in_valid,
	output logic                                     in_stall,
	input  wire  signed [ldpm_pkg::COORD_WIDTH-1:0]  x_in,
	input  wire  signed [ldpm_pkg::COORD_WIDTH-1:0]  y_in,
	output logic                                     out_valid,
	input  wire                                      out_stall,
	output logic signed [ldpm_pkg::COORD_WIDTH-1:0]  x_out,
	output logic signed [ldpm_pkg::COORD_WIDTH-1:0]  y_out,
	output logic                                     saturated,
	output logic                                     div_fault
);
	import ldpm_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int DIFF_W = ((CW + 12 > 32) ? CW + 12 : 32) + 1;
	localparam int CMP_W  = DIFF_W + 8;
	localparam int SUM_W  = 44;
	localparam int TX_W   = 42;
	localparam int NUM_W  = 35;

	typedef struct packed {
		logic neg_x;
		logic ovf_x;
		logic neg_y;
		logic ovf_y;
		logic fault;
	} norm_side_t;

	typedef struct packed {
		logic signed [31:0]     xn;
		logic signed [31:0]     yn;
		logic signed [TX_W-1:0] tx;
		logic signed [TX_W-1:0] ty;
		logic                   neg;
		logic                   ovf;
		logic                   sat;
		logic                   fault;
	} rf_side_t;

	// Configuration registers.
	logic        [31:0] focal_x_q, focal_y_q;
	logic signed [31:0] center_x_q, center_y_q;
	logic        [63:0] rad12_q, tang12_q, rad34_q, rad56_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_RESET;
			focal_y_q  <= FOCAL_RESET;
			center_x_q <= '0;
			center_y_q <= '0;
			rad12_q    <= '0;
			tang12_q   <= '0;
			rad34_q    <= '0;
			rad56_q    <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_FOCAL_X:   focal_x_q  <= wr_data[31:0];
				CFG_FOCAL_Y:   focal_y_q  <= wr_data[31:0];
				CFG_CENTER_X:  center_x_q <= wr_data[31:0];
				CFG_CENTER_Y:  center_y_q <= wr_data[31:0];
				CFG_RADIAL_12: rad12_q    <= wr_data;
				CFG_TANG_12:   tang12_q   <= wr_data;
				CFG_RADIAL_34: rad34_q    <= wr_data;
				CFG_RADIAL_56: rad56_q    <= wr_data;
				default: ;
			endcase
		end
	end

	logic signed [31:0] k1, k2, k3, k4, k5, k6, p1, p2;
	assign k1 = rad12_q[31:0];
	assign k2 = rad12_q[63:32];
	assign k3 = rad34_q[31:0];
	assign k4 = rad34_q[63:32];
	assign k5 = rad56_q[31:0];
	assign k6 = rad56_q[63:32];
	assign p1 = tang12_q[31:0];
	assign p2 = tang12_q[63:32];

	// The whole pipeline advances unless a finished result waits on the output.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Valid bits.
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic                  v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17;
	logic [DIV_STAGES-1:0] dv1_v_s, dv2_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			v_s11   <= 1'b0;
			v_s12   <= 1'b0;
			v_s13   <= 1'b0;
			v_s14   <= 1'b0;
			v_s15   <= 1'b0;
			v_s16   <= 1'b0;
			v_s17   <= 1'b0;
			dv1_v_s <= '0;
			dv2_v_s <= '0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			dv1_v_s <= {dv1_v_s[DIV_STAGES-2:0], v_s2};
			v_s3    <= dv1_v_s[DIV_STAGES-1];
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			v_s9    <= v_s8;
			v_s10   <= v_s9;
			v_s11   <= v_s10;
			v_s12   <= v_s11;
			dv2_v_s <= {dv2_v_s[DIV_STAGES-2:0], v_s12};
			v_s13   <= dv2_v_s[DIV_STAGES-1];
			v_s14   <= v_s13;
			v_s15   <= v_s14;
			v_s16   <= v_s15;
			v_s17   <= v_s16;
		end
	end

	// Stage 1: input register.
	logic signed [CW-1:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_in;
			y_s1 <= y_in;
		end
	end

	// Stage 2: offset from the principal point, magnitude and overflow check.
	logic signed [DIFF_W-1:0] diff_x, diff_y;
	logic        [DIFF_W-1:0] mag_x, mag_y;
	logic                     ovf_x, ovf_y;
	logic        [DIFF_W-1:0] mag_x_s2, mag_y_s2;
	logic                     neg_x_s2, neg_y_s2, ovf_x_s2, ovf_y_s2, fault_s2;

	assign diff_x = (DIFF_W'(x_s1) <<< 12) - DIFF_W'(center_x_q);
	assign diff_y = (DIFF_W'(y_s1) <<< 12) - DIFF_W'(center_y_q);
	assign mag_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
	assign mag_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

	// The quotient reaches 2^32 when the magnitude is at least focal * 2^8.
	assign ovf_x = (CMP_W'(mag_x) >= CMP_W'({focal_x_q, 8'b0}))
		|| (CMP_W'(mag_x) >= (CMP_W'(1) << 39));
	assign ovf_y = (CMP_W'(mag_y) >= CMP_W'({focal_y_q, 8'b0}))
		|| (CMP_W'(mag_y) >= (CMP_W'(1) << 39));

	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s2 <= mag_x;
			mag_y_s2 <= mag_y;
			neg_x_s2 <= diff_x[DIFF_W-1];
			neg_y_s2 <= diff_y[DIFF_W-1];
			ovf_x_s2 <= ovf_x;
			ovf_y_s2 <= ovf_y;
			fault_s2 <= (focal_x_q == '0) || (focal_y_q == '0);
		end
	end

	// Normalization dividers: (mag * 2^24) / focal.
	logic [QUO_W-1:0] quo_x, quo_y;

	ldpm_div u_div_x (
		.clk    (clk),
		.en     (en),
		.num_hi (DIV_W'(mag_x_s2 >> 8)),
		.num_lo ({mag_x_s2[7:0], 24'b0}),
		.den    (DIV_W'(focal_x_q)),
		.quo    (quo_x)
	);

	ldpm_div u_div_y (
		.clk    (clk),
		.en     (en),
		.num_hi (DIV_W'(mag_y_s2 >> 8)),
		.num_lo ({mag_y_s2[7:0], 24'b0}),
		.den    (DIV_W'(focal_y_q)),
		.quo    (quo_y)
	);

	norm_side_t dv1_sb_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			dv1_sb_s[0] <= '{neg_x: neg_x_s2, ovf_x: ovf_x_s2, neg_y: neg_y_s2,
				ovf_y: ovf_y_s2, fault: fault_s2};
			for (int i = 1; i < DIV_STAGES; i++) begin
				dv1_sb_s[i] <= dv1_sb_s[i-1];
			end
		end
	end

	// Stage 3: signed, clipped normalized coordinates in Q.24.
	clip_t              nq_x, nq_y;
	logic signed [31:0] xn_s3, yn_s3;
	logic               sat_s3, fault_s3;

	assign nq_x = quo_sat(dv1_sb_s[DIV_STAGES-1].neg_x, dv1_sb_s[DIV_STAGES-1].ovf_x, quo_x);
	assign nq_y = quo_sat(dv1_sb_s[DIV_STAGES-1].neg_y, dv1_sb_s[DIV_STAGES-1].ovf_y, quo_y);

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s3    <= 32'(nq_x.val);
			yn_s3    <= 32'(nq_y.val);
			sat_s3   <= nq_x.clipped || nq_y.clipped;
			fault_s3 <= dv1_sb_s[DIV_STAGES-1].fault;
		end
	end

	// Stage 4: squares and cross product.
	logic signed [63:0] pxx_s4, pyy_s4, pxy_s4;
	logic signed [31:0] xn_s4, yn_s4;
	logic               sat_s4, fault_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s4   <= xn_s3 * xn_s3;
			pyy_s4   <= yn_s3 * yn_s3;
			pxy_s4   <= xn_s3 * yn_s3;
			xn_s4    <= xn_s3;
			yn_s4    <= yn_s3;
			sat_s4   <= sat_s3;
			fault_s4 <= fault_s3;
		end
	end

	// Stage 5: rescale to Q.24 and form r2.
	clip_t              c_xx, c_yy, c_xy, c_r2;
	logic signed [31:0] xx_s5, yy_s5, xy_s5, r2_s5, xn_s5, yn_s5;
	logic               sat_s5, fault_s5;

	assign c_xx = clip64(pxx_s4 >>> 24, 32);
	assign c_yy = clip64(pyy_s4 >>> 24, 32);
	assign c_xy = clip64(pxy_s4 >>> 24, 32);
	assign c_r2 = clip64((pxx_s4 >>> 24) + (pyy_s4 >>> 24), 32);

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s5    <= 32'(c_xx.val);
			yy_s5    <= 32'(c_yy.val);
			xy_s5    <= 32'(c_xy.val);
			r2_s5    <= 32'(c_r2.val);
			xn_s5    <= xn_s4;
			yn_s5    <= yn_s4;
			sat_s5   <= sat_s4 || c_xx.clipped || c_yy.clipped || c_xy.clipped
				|| c_r2.clipped;
			fault_s5 <= fault_s4;
		end
	end

	// Stage 6: r2 squared and the tangential sums.
	clip_t              c_sx, c_sy;
	logic signed [63:0] r4p_s6;
	logic signed [31:0] sx_s6, sy_s6, xy_s6, r2_s6, xn_s6, yn_s6;
	logic               sat_s6, fault_s6;

	assign c_sx = clip64(64'(r2_s5) + (64'(xx_s5) <<< 1), 32);
	assign c_sy = clip64(64'(r2_s5) + (64'(yy_s5) <<< 1), 32);

	always_ff @(posedge clk) begin
		if (en) begin
			r4p_s6   <= r2_s5 * r2_s5;
			sx_s6    <= 32'(c_sx.val);
			sy_s6    <= 32'(c_sy.val);
			xy_s6    <= xy_s5;
			r2_s6    <= r2_s5;
			xn_s6    <= xn_s5;
			yn_s6    <= yn_s5;
			sat_s6   <= sat_s5 || c_sx.clipped || c_sy.clipped;
			fault_s6 <= fault_s5;
		end
	end

	// Stage 7: r4 and the tangential products.
	clip_t              c_r4;
	logic signed [31:0] r4_s7, r2_s7, xn_s7, yn_s7;
	logic signed [63:0] tp1_s7, tp2_s7, tp3_s7, tp4_s7;
	logic               sat_s7, fault_s7;

	assign c_r4 = clip64(r4p_s6 >>> 24, 32);

	always_ff @(posedge clk) begin
		if (en) begin
			r4_s7    <= 32'(c_r4.val);
			tp1_s7   <= p1 * xy_s6;
			tp2_s7   <= p2 * sx_s6;
			tp3_s7   <= p1 * sy_s6;
			tp4_s7   <= p2 * xy_s6;
			r2_s7    <= r2_s6;
			xn_s7    <= xn_s6;
			yn_s7    <= yn_s6;
			sat_s7   <= sat_s6 || c_r4.clipped;
			fault_s7 <= fault_s6;
		end
	end

	// Stage 8: r6 product, coefficient products on r2 and r4, tangential sums.
	logic signed [63:0]     r6p_s8, m1_s8, m2_s8, m4_s8, m5_s8;
	logic signed [TX_W-1:0] tx_s8, ty_s8;
	logic signed [31:0]     xn_s8, yn_s8;
	logic                   sat_s8, fault_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			r6p_s8   <= r4_s7 * r2_s7;
			m1_s8    <= k1 * r2_s7;
			m4_s8    <= k4 * r2_s7;
			m2_s8    <= k2 * r4_s7;
			m5_s8    <= k5 * r4_s7;
			tx_s8    <= TX_W'(((tp1_s7 >>> 24) <<< 1) + (tp2_s7 >>> 24));
			ty_s8    <= TX_W'((tp3_s7 >>> 24) + ((tp4_s7 >>> 24) <<< 1));
			xn_s8    <= xn_s7;
			yn_s8    <= yn_s7;
			sat_s8   <= sat_s7;
			fault_s8 <= fault_s7;
		end
	end

	// Stage 9: r6 and partial numerator and denominator sums.
	clip_t                  c_r6;
	logic signed [31:0]     r6_s9, xn_s9, yn_s9;
	logic signed [SUM_W-1:0] nsum_s9, dsum_s9;
	logic signed [TX_W-1:0] tx_s9, ty_s9;
	logic                   sat_s9, fault_s9;

	assign c_r6 = clip64(r6p_s8 >>> 24, 32);

	always_ff @(posedge clk) begin
		if (en) begin
			r6_s9    <= 32'(c_r6.val);
			nsum_s9  <= SUM_W'((64'sd1 <<< 28) + (m1_s8 >>> 24) + (m2_s8 >>> 24));
			dsum_s9  <= SUM_W'((64'sd1 <<< 28) + (m4_s8 >>> 24) + (m5_s8 >>> 24));
			tx_s9    <= tx_s8;
			ty_s9    <= ty_s8;
			xn_s9    <= xn_s8;
			yn_s9    <= yn_s8;
			sat_s9   <= sat_s8 || c_r6.clipped;
			fault_s9 <= fault_s8;
		end
	end

	// Stage 10: coefficient products on r6.
	logic signed [63:0]      m3_s10, m6_s10;
	logic signed [SUM_W-1:0] nsum_s10, dsum_s10;
	logic signed [TX_W-1:0]  tx_s10, ty_s10;
	logic signed [31:0]      xn_s10, yn_s10;
	logic                    sat_s10, fault_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			m3_s10    <= k3 * r6_s9;
			m6_s10    <= k6 * r6_s9;
			nsum_s10  <= nsum_s9;
			dsum_s10  <= dsum_s9;
			tx_s10    <= tx_s9;
			ty_s10    <= ty_s9;
			xn_s10    <= xn_s9;
			yn_s10    <= yn_s9;
			sat_s10   <= sat_s9;
			fault_s10 <= fault_s9;
		end
	end

	// Stage 11: full numerator and denominator.
	logic signed [SUM_W-1:0] num_s11, den_s11;
	logic signed [TX_W-1:0]  tx_s11, ty_s11;
	logic signed [31:0]      xn_s11, yn_s11;
	logic                    sat_s11, fault_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s11   <= SUM_W'(64'(nsum_s10) + (m3_s10 >>> 24));
			den_s11   <= SUM_W'(64'(dsum_s10) + (m6_s10 >>> 24));
			tx_s11    <= tx_s10;
			ty_s11    <= ty_s10;
			xn_s11    <= xn_s10;
			yn_s11    <= yn_s10;
			sat_s11   <= sat_s10;
			fault_s11 <= fault_s10;
		end
	end

	// Stage 12: zero denominator check, numerator clip, magnitudes for the divider.
	clip_t                   c_num;
	logic signed [SUM_W-1:0] num_c;
	logic        [SUM_W-1:0] anum, aden;
	logic        [NUM_W-1:0] anum_s12;
	logic        [DIV_W-1:0] aden_s12;
	logic                    neg_s12, ovf_s12;
	logic signed [TX_W-1:0]  tx_s12, ty_s12;
	logic signed [31:0]      xn_s12, yn_s12;
	logic                    sat_s12, fault_s12;

	assign c_num = clip64(64'(num_s11), NUM_W);
	assign num_c = SUM_W'(c_num.val);
	assign anum  = num_c[SUM_W-1] ? SUM_W'(-num_c) : SUM_W'(num_c);
	assign aden  = den_s11[SUM_W-1] ? SUM_W'(-den_s11) : SUM_W'(den_s11);

	always_ff @(posedge clk) begin
		if (en) begin
			anum_s12  <= NUM_W'(anum);
			aden_s12  <= DIV_W'(aden);
			neg_s12   <= num_c[SUM_W-1] ^ den_s11[SUM_W-1];
			// The quotient reaches 2^32 when |num| is at least |den| * 16.
			ovf_s12   <= (48'(anum) >= (48'(aden) << 4));
			tx_s12    <= tx_s11;
			ty_s12    <= ty_s11;
			xn_s12    <= xn_s11;
			yn_s12    <= yn_s11;
			sat_s12   <= sat_s11 || c_num.clipped;
			fault_s12 <= fault_s11 || (den_s11 == '0);
		end
	end

	// Rational factor divider: (|num| * 2^28) / |den|.
	logic [QUO_W-1:0] quo_r;

	ldpm_div u_div_r (
		.clk    (clk),
		.en     (en),
		.num_hi (DIV_W'(anum_s12 >> 4)),
		.num_lo ({anum_s12[3:0], 28'b0}),
		.den    (aden_s12),
		.quo    (quo_r)
	);

	rf_side_t dv2_sb_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			dv2_sb_s[0] <= '{xn: xn_s12, yn: yn_s12, tx: tx_s12, ty: ty_s12,
				neg: neg_s12, ovf: ovf_s12, sat: sat_s12, fault: fault_s12};
			for (int i = 1; i < DIV_STAGES; i++) begin
				dv2_sb_s[i] <= dv2_sb_s[i-1];
			end
		end
	end

	// Stage 13: signed, clipped rational factor in Q.28.
	clip_t                  c_rf;
	logic signed [31:0]     rf_s13, xn_s13, yn_s13;
	logic signed [TX_W-1:0] tx_s13, ty_s13;
	logic                   sat_s13, fault_s13;

	assign c_rf = quo_sat(dv2_sb_s[DIV_STAGES-1].neg, dv2_sb_s[DIV_STAGES-1].ovf, quo_r);

	always_ff @(posedge clk) begin
		if (en) begin
			rf_s13    <= 32'(c_rf.val);
			xn_s13    <= dv2_sb_s[DIV_STAGES-1].xn;
			yn_s13    <= dv2_sb_s[DIV_STAGES-1].yn;
			tx_s13    <= dv2_sb_s[DIV_STAGES-1].tx;
			ty_s13    <= dv2_sb_s[DIV_STAGES-1].ty;
			sat_s13   <= dv2_sb_s[DIV_STAGES-1].sat || c_rf.clipped;
			fault_s13 <= dv2_sb_s[DIV_STAGES-1].fault;
		end
	end

	// Stage 14: radial scaling products.
	logic signed [63:0]     pxr_s14, pyr_s14;
	logic signed [TX_W-1:0] tx_s14, ty_s14;
	logic                   sat_s14, fault_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			pxr_s14   <= xn_s13 * rf_s13;
			pyr_s14   <= yn_s13 * rf_s13;
			tx_s14    <= tx_s13;
			ty_s14    <= ty_s13;
			sat_s14   <= sat_s13;
			fault_s14 <= fault_s13;
		end
	end

	// Stage 15: radial plus tangential part, clipped to 31 bits.
	clip_t              c_xnew, c_ynew;
	logic signed [30:0] xnew_s15, ynew_s15;
	logic               sat_s15, fault_s15;

	assign c_xnew = clip64((pxr_s14 >>> 28) + (64'(tx_s14) >>> 4), 31);
	assign c_ynew = clip64((pyr_s14 >>> 28) + (64'(ty_s14) >>> 4), 31);

	always_ff @(posedge clk) begin
		if (en) begin
			xnew_s15  <= 31'(c_xnew.val);
			ynew_s15  <= 31'(c_ynew.val);
			sat_s15   <= sat_s14 || c_xnew.clipped || c_ynew.clipped;
			fault_s15 <= fault_s14;
		end
	end

	// Stage 16: denormalize by the focal lengths.
	logic signed [32:0] fx_sgn, fy_sgn;
	logic signed [63:0] pxf_s16, pyf_s16;
	logic               sat_s16, fault_s16;

	assign fx_sgn = {1'b0, focal_x_q};
	assign fy_sgn = {1'b0, focal_y_q};

	always_ff @(posedge clk) begin
		if (en) begin
			pxf_s16   <= xnew_s15 * fx_sgn;
			pyf_s16   <= ynew_s15 * fy_sgn;
			sat_s16   <= sat_s15;
			fault_s16 <= fault_s15;
		end
	end

	// Stage 17: add the centre, convert to Q12.4 and clip; on a fault show the centre.
	clip_t                c_ox, c_oy, c_cx, c_cy;
	logic signed [CW-1:0] x_s17, y_s17;
	logic                 sat_s17, fault_s17;

	assign c_ox = clip64(((pxf_s16 >>> 24) + 64'(center_x_q)) >>> 12, CW);
	assign c_oy = clip64(((pyf_s16 >>> 24) + 64'(center_y_q)) >>> 12, CW);
	assign c_cx = clip64(64'(center_x_q) >>> 12, CW);
	assign c_cy = clip64(64'(center_y_q) >>> 12, CW);

	always_ff @(posedge clk) begin
		if (en) begin
			if (fault_s16) begin
				x_s17   <= CW'(c_cx.val);
				y_s17   <= CW'(c_cy.val);
				sat_s17 <= c_cx.clipped || c_cy.clipped;
			end else begin
				x_s17   <= CW'(c_ox.val);
				y_s17   <= CW'(c_oy.val);
				sat_s17 <= sat_s16 || c_ox.clipped || c_oy.clipped;
			end
			fault_s17 <= fault_s16;
		end
	end

	assign out_valid = v_s17;
	assign x_out     = x_s17;
	assign y_out     = y_s17;
	assign saturated = sat_s17;
	assign div_fault = fault_s17;

	// A stalled pipeline holds its occupancy.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (v_s13 == $past(v_s13)) && (dv2_v_s == $past(dv2_v_s))
			&& (v_s3 == $past(v_s3)))
		else $error("pipeline valid bits moved during a stall");

	// An advancing pipeline moves the checked valid bits one stage on.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (dv2_v_s[0] == $past(v_s12)) && (v_s13 == $past(dv2_v_s[DIV_STAGES-1]))
			&& (v_s2 == $past(v_s1)))
		else $error("pipeline valid bits lost or repeated");

endmodule

`default_nettype wire
